[sv/trigger_road_hit_coincidence_top_assert.svh]
// Assertion macros for the road coincidence block.
// They sample on clk_i and are off while rst_ni is low.
`ifndef TRIGGER_ROAD_HIT_COINCIDENCE_TOP_ASSERT_SVH
`define TRIGGER_ROAD_HIT_COINCIDENCE_TOP_ASSERT_SVH

// Same-cycle implication.
`define TRHC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define TRHC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

// Implication after the fixed item latency.
`define TRHC_ASSERT_LAT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) \
    (ante) |-> ##ResultLatency (cons)) else $error(msg);

`endif

[sv/trhc_pkg.sv]
package trhc_pkg;

  localparam int Planes       = 8;
  localparam int PlaneW       = $clog2(Planes);
  localparam int MarginUpX    = 0;
  localparam int MarginDownX  = 0;
  localparam int MarginUpUv   = 0;
  localparam int MarginDownUv = 0;

  localparam int FixW  = 40;           // Q8.32
  localparam int HalfW = FixW / 2;     // pitch split for the shared multiplier
  localparam int ProdW = 17;           // road_size * (index + 1) < 2^17
  localparam int CoefW = ProdW + 3;    // signed 2*prod + 1 +/- 2*margin
  localparam int PartW = CoefW + HalfW + 1;
  localparam int SumW  = 62;           // doubled bounds, exact

  localparam int AddrW = 5;
  localparam int DataW = 32;
  localparam int ResultLatency = 7;

  typedef enum logic [1:0] {
    ModeHit   = 2'd0,
    ModeTick  = 2'd1,
    ModeClear = 2'd2,
    ModeNop   = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    KindX    = 2'd0,
    KindU    = 2'd1,
    KindV    = 2'd2,
    KindNone = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    RegSector = 3'd0,
    RegSize   = 3'd1,
    RegIdxX   = 3'd2,
    RegIdxU   = 3'd3,
    RegIdxV   = 3'd4,
    RegXThr   = 3'd5,
    RegUvThr  = 3'd6,
    RegWindow = 3'd7
  } reg_e;

  typedef enum logic [2:0] {
    StIdle,
    StCoef,
    StMulLo,
    StMulHi,
    StSum,
    StUpdate,
    StResult
  } state_e;

  typedef struct packed {
    logic load_in;
    logic coef;
    logic mul_lo;
    logic mul_hi;
    logic sum;
    logic update;
    logic result;
  } cmd_t;

  typedef struct packed {
    logic [7:0] sector;
    logic [6:0] size;
    logic [9:0] idx_x;
    logic [9:0] idx_u;
    logic [9:0] idx_v;
    logic [3:0] x_thr;
    logic [3:0] uv_thr;
    logic [3:0] window;
  } cfg_t;

endpackage

[sv/trhc_cfg.sv]
module trhc_cfg (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel_i,
  input  logic                        penable_i,
  input  logic                        pwrite_i,
  input  logic [trhc_pkg::AddrW-1:0]  paddr_i,
  input  logic [trhc_pkg::DataW-1:0]  pwdata_i,
  output logic [trhc_pkg::DataW-1:0]  prdata_o,
  output logic                        pready_o,
  output trhc_pkg::cfg_t              cfg_o
);
  import trhc_pkg::*;

  cfg_t cfg_q, cfg_d;
  reg_e sel;
  logic wr_en;

  assign sel      = reg_e'(paddr_i[AddrW-1:2]);
  assign wr_en    = psel_i && penable_i && pwrite_i;
  assign pready_o = 1'b1;
  assign cfg_o    = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (sel)
        RegSector: cfg_d.sector = pwdata_i[7:0];
        RegSize:   cfg_d.size   = pwdata_i[6:0];
        RegIdxX:   cfg_d.idx_x  = pwdata_i[9:0];
        RegIdxU:   cfg_d.idx_u  = pwdata_i[9:0];
        RegIdxV:   cfg_d.idx_v  = pwdata_i[9:0];
        RegXThr:   cfg_d.x_thr  = pwdata_i[3:0];
        RegUvThr:  cfg_d.uv_thr = pwdata_i[3:0];
        RegWindow: cfg_d.window = pwdata_i[3:0];
      endcase
    end
  end

  always_comb begin
    unique case (sel)
      RegSector: prdata_o = DataW'(cfg_q.sector);
      RegSize:   prdata_o = DataW'(cfg_q.size);
      RegIdxX:   prdata_o = DataW'(cfg_q.idx_x);
      RegIdxU:   prdata_o = DataW'(cfg_q.idx_u);
      RegIdxV:   prdata_o = DataW'(cfg_q.idx_v);
      RegXThr:   prdata_o = DataW'(cfg_q.x_thr);
      RegUvThr:  prdata_o = DataW'(cfg_q.uv_thr);
      RegWindow: prdata_o = DataW'(cfg_q.window);
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.sector <= 8'd0;
      cfg_q.size   <= 7'd8;
      cfg_q.idx_x  <= 10'd0;
      cfg_q.idx_u  <= 10'd0;
      cfg_q.idx_v  <= 10'd0;
      cfg_q.x_thr  <= 4'd3;
      cfg_q.uv_thr <= 4'd3;
      cfg_q.window <= 4'd8;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

[sv/trhc_ctrl.sv]
module trhc_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  output logic           busy_o,
  output trhc_pkg::cmd_t cmd_o
);
  import trhc_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  // fixed sequence, same for every mode
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      StIdle: begin
        if (start_i) begin
          cmd_o.load_in = 1'b1;
          state_d       = StCoef;
        end
      end
      StCoef: begin
        cmd_o.coef = 1'b1;
        state_d    = StMulLo;
      end
      StMulLo: begin
        cmd_o.mul_lo = 1'b1;
        state_d      = StMulHi;
      end
      StMulHi: begin
        cmd_o.mul_hi = 1'b1;
        state_d      = StSum;
      end
      StSum: begin
        cmd_o.sum = 1'b1;
        state_d   = StUpdate;
      end
      StUpdate: begin
        cmd_o.update = 1'b1;
        state_d      = StResult;
      end
      StResult: begin
        cmd_o.result = 1'b1;
        state_d      = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  assign busy_o = (state_q != StIdle);

endmodule

[sv/trhc_dp.sv]
module trhc_dp (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  trhc_pkg::cmd_t                    cmd_i,
  input  trhc_pkg::cfg_t                    cfg_i,
  input  logic [1:0]                        mode_i,
  input  logic [7:0]                        hit_sector_i,
  input  logic [trhc_pkg::PlaneW-1:0]       hit_plane_i,
  input  logic [1:0]                        hit_kind_i,
  input  logic signed [trhc_pkg::FixW-1:0]  hit_shift_i,
  input  logic signed [trhc_pkg::FixW-1:0]  hit_pitch_over_z_i,
  input  logic signed [trhc_pkg::FixW-1:0]  hit_slope_i,
  input  logic                              hit_noise_i,
  output logic                              result_valid_o,
  output logic                              hit_accepted_o,
  output logic                              coincidence_o,
  output logic [3:0]                        real_hit_count_o,
  output logic [2:0]                        real_x_count_o,
  output logic [2:0]                        real_uv_count_o,
  output logic                              low_resolution_o,
  output logic [trhc_pkg::Planes-1:0]       plane_mask_o
);
  import trhc_pkg::*;

  // captured item
  logic [1:0]              mode_q;
  logic [7:0]              sector_q;
  logic [PlaneW-1:0]       plane_q;
  logic [1:0]              kind_q;
  logic signed [FixW-1:0]  shift_q, pitch_q, slope_q;
  logic                    hit_noise_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      mode_q      <= mode_i;
      sector_q    <= hit_sector_i;
      plane_q     <= hit_plane_i;
      kind_q      <= hit_kind_i;
      shift_q     <= hit_shift_i;
      pitch_q     <= hit_pitch_over_z_i;
      slope_q     <= hit_slope_i;
      hit_noise_q <= hit_noise_i;
    end
  end

  // ---- window coefficients (doubled): clo = 2*rs*idx + 1 - 2*down
  logic [9:0]              idx_sel;
  logic [10:0]             idx_inc;
  logic [ProdW-1:0]        rs_idx, rs_idx1;
  logic [CoefW-1:0]        marg_dn, marg_up;
  logic signed [CoefW-1:0] clo_q, chi_q;

  always_comb begin
    unique case (kind_e'(kind_q))
      KindU:   idx_sel = cfg_i.idx_u;
      KindV:   idx_sel = cfg_i.idx_v;
      KindX:   idx_sel = cfg_i.idx_x;
      KindNone: idx_sel = cfg_i.idx_x;
    endcase
  end

  assign idx_inc = {1'b0, idx_sel} + 11'd1;
  assign rs_idx  = ProdW'(cfg_i.size) * ProdW'(idx_sel);
  assign rs_idx1 = ProdW'(cfg_i.size) * ProdW'(idx_inc);
  assign marg_dn = (kind_q == KindX) ? CoefW'(2 * MarginDownX) : CoefW'(2 * MarginDownUv);
  assign marg_up = (kind_q == KindX) ? CoefW'(2 * MarginUpX) : CoefW'(2 * MarginUpUv);

  always_ff @(posedge clk_i) begin
    if (cmd_i.coef) begin
      clo_q <= {2'b00, rs_idx, 1'b0} + CoefW'(1) - marg_dn;
      chi_q <= {2'b00, rs_idx1, 1'b0} + CoefW'(1) + marg_up;
    end
  end

  // ---- shared multiplier pair, low pitch half then high pitch half
  logic signed [HalfW:0]   mop;
  logic signed [PartW-1:0] prod_lo, prod_hi;
  logic signed [PartW-1:0] clo_pl_q, clo_ph_q, chi_pl_q, chi_ph_q;

  assign mop     = cmd_i.mul_lo ? {1'b0, pitch_q[HalfW-1:0]}
                                : {pitch_q[FixW-1], pitch_q[FixW-1:HalfW]};
  assign prod_lo = clo_q * mop;
  assign prod_hi = chi_q * mop;

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_lo) begin
      clo_pl_q <= prod_lo;
      chi_pl_q <= prod_hi;
    end
    if (cmd_i.mul_hi) begin
      clo_ph_q <= prod_lo;
      chi_ph_q <= prod_hi;
    end
  end

  // ---- doubled bounds
  logic signed [SumW-1:0] lo2_q, hi2_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.sum) begin
      lo2_q <= (SumW'(shift_q) <<< 1) + SumW'(clo_pl_q) + (SumW'(clo_ph_q) <<< HalfW);
      hi2_q <= (SumW'(shift_q) <<< 1) + SumW'(chi_pl_q) + (SumW'(chi_ph_q) <<< HalfW);
    end
  end

  // ---- window test and slot update
  logic signed [SumW-1:0] s2;
  logic                   slope_pos, in_win, hit_ok;
  logic [Planes-1:0]      valid_q, valid_d, snoise_q, snoise_d;
  logic [3:0]             age_q [Planes];
  logic [3:0]             age_d [Planes];
  logic [4:0]             age_inc [Planes];
  logic                   acc_q, acc_d;

  assign s2        = SumW'(slope_q) <<< 1;
  assign slope_pos = !slope_q[FixW-1] && (|slope_q);
  assign in_win    = slope_pos ? ((s2 > lo2_q) && (s2 < hi2_q))
                               : ((s2 > hi2_q) && (s2 < lo2_q));
  assign hit_ok    = (sector_q == cfg_i.sector) && (kind_q != KindNone) && in_win &&
                     (!valid_q[plane_q] || (!hit_noise_q && snoise_q[plane_q]));

  always_comb begin
    for (int p = 0; p < Planes; p++) begin
      age_inc[p] = {1'b0, age_q[p]} + 5'd1;
    end
  end

  always_comb begin
    valid_d  = valid_q;
    snoise_d = snoise_q;
    age_d    = age_q;
    acc_d    = acc_q;
    if (cmd_i.update) begin
      acc_d = 1'b0;
      unique case (mode_e'(mode_q))
        ModeHit: begin
          if (hit_ok) begin
            valid_d[plane_q]  = 1'b1;
            snoise_d[plane_q] = hit_noise_q;
            age_d[plane_q]    = '0;
            acc_d             = 1'b1;
          end
        end
        ModeTick: begin
          for (int p = 0; p < Planes; p++) begin
            if (valid_q[p]) begin
              if (age_inc[p] >= {1'b0, cfg_i.window}) begin
                valid_d[p]  = 1'b0;
                snoise_d[p] = 1'b0;
                age_d[p]    = '0;
              end else begin
                age_d[p] = age_inc[p][3:0];
              end
            end
          end
        end
        ModeClear: begin
          valid_d  = '0;
          snoise_d = '0;
          age_d    = '{default: '0};
        end
        ModeNop: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      snoise_q <= '0;
      age_q    <= '{default: '0};
      acc_q    <= 1'b0;
    end else begin
      valid_q  <= valid_d;
      snoise_q <= snoise_d;
      age_q    <= age_d;
      acc_q    <= acc_d;
    end
  end

  // ---- coincidence summary of the stored hits
  logic [1:0] nx1, nx2, nu, nv;
  logic [3:0] nreal, x_sum, uv_sum;
  logic [2:0] rx, ruv, lowh, highh;
  logic       mature, horiz, stereo;

  always_comb begin
    nx1    = '0;
    nx2    = '0;
    nu     = '0;
    nv     = '0;
    nreal  = '0;
    rx     = '0;
    ruv    = '0;
    lowh   = '0;
    highh  = '0;
    mature = 1'b0;
    for (int p = 0; p < Planes; p++) begin
      if (valid_q[p]) begin
        if (p < 2) nx1 = nx1 + 2'd1;
        if (p > 5) nx2 = nx2 + 2'd1;
        if (p == 2 || p == 4) nu = nu + 2'd1;
        if (p == 3 || p == 5) nv = nv + 2'd1;
        if (age_inc[p] == {1'b0, cfg_i.window}) mature = 1'b1;
        if (!snoise_q[p]) begin
          nreal = nreal + 4'd1;
          if (p < 2 || p > 5) rx = rx + 3'd1;
          else                ruv = ruv + 3'd1;
          if (p < Planes / 2) lowh = lowh + 3'd1;
          else                highh = highh + 3'd1;
        end
      end
    end
  end

  assign x_sum  = {2'b00, nx1} + {2'b00, nx2};
  assign uv_sum = {2'b00, nu} + {2'b00, nv};
  assign horiz  = (|nx1) && (|nx2) && (x_sum >= cfg_i.x_thr);
  assign stereo = (cfg_i.uv_thr == 4'd0) ||
                  ((|nu) && (|nv) && (uv_sum >= cfg_i.uv_thr));

  always_ff @(posedge clk_i) begin
    if (cmd_i.result) begin
      hit_accepted_o   <= acc_q;
      coincidence_o    <= horiz && stereo && mature;
      real_hit_count_o <= nreal;
      real_x_count_o   <= rx;
      real_uv_count_o  <= ruv;
      low_resolution_o <= (lowh != 3'(Planes / 2)) || (highh != 3'(Planes / 2));
      plane_mask_o     <= valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      result_valid_o <= 1'b0;
    end else begin
      result_valid_o <= cmd_i.result;
    end
  end

endmodule

[sv/trigger_road_hit_coincidence_top.sv]
// An accepted start steps the controller through Coef, MulLo, MulHi, Sum, Update, Result;
// result_valid_o is registered from Result. busy is high outside idle, so a new item is
// taken once the last is through; the multiplier pair takes the pitch as two 20-bit halves.
// Reset (rst_ni low, async): registers return to defaults, road empty, controller idle.
// Results are one-cycle strobes; the receiver cannot stall them.
`include "trigger_road_hit_coincidence_top_assert.svh"

module trigger_road_hit_coincidence_top (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // item command port
  input  logic                              start,
  output logic                              busy,
  input  logic [1:0]                        mode_i,
  input  logic [7:0]                        hit_sector_i,
  input  logic [trhc_pkg::PlaneW-1:0]       hit_plane_i,
  input  logic [1:0]                        hit_kind_i,
  input  logic signed [trhc_pkg::FixW-1:0]  hit_shift_i,
  input  logic signed [trhc_pkg::FixW-1:0]  hit_pitch_over_z_i,
  input  logic signed [trhc_pkg::FixW-1:0]  hit_slope_i,
  input  logic                              hit_noise_i,
  // register port
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [trhc_pkg::AddrW-1:0]        paddr,
  input  logic [trhc_pkg::DataW-1:0]        pwdata,
  output logic [trhc_pkg::DataW-1:0]        prdata,
  output logic                              pready,
  // result
  output logic                              result_valid_o,
  output logic                              hit_accepted_o,
  output logic                              coincidence_o,
  output logic [3:0]                        real_hit_count_o,
  output logic [2:0]                        real_x_count_o,
  output logic [2:0]                        real_uv_count_o,
  output logic                              low_resolution_o,
  output logic [trhc_pkg::Planes-1:0]       plane_mask_o
);
  import trhc_pkg::*;

  cfg_t cfg;
  cmd_t cmd;

  // Register file: eight registers at byte addresses 4*i, written on the
  // access phase, read combinationally.
  trhc_cfg u_cfg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .psel_i    (psel),
    .penable_i (penable),
    .pwrite_i  (pwrite),
    .paddr_i   (paddr),
    .pwdata_i  (pwdata),
    .prdata_o  (prdata),
    .pready_o  (pready),
    .cfg_o     (cfg)
  );

  // Sequencer: every item walks the same steps, whatever its mode:
  //   capture -> coefficients -> low-half products -> high-half products
  //   -> bounds -> window test + slot update -> result register.
  trhc_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .busy_o  (busy),
    .cmd_o   (cmd)
  );

  // Datapath: slope window in doubled fixed point (exact, no rounding),
  // per-plane slots (valid, noise, age) and the coincidence summary.
  trhc_dp u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (cmd),
    .cfg_i              (cfg),
    .mode_i             (mode_i),
    .hit_sector_i       (hit_sector_i),
    .hit_plane_i        (hit_plane_i),
    .hit_kind_i         (hit_kind_i),
    .hit_shift_i        (hit_shift_i),
    .hit_pitch_over_z_i (hit_pitch_over_z_i),
    .hit_slope_i        (hit_slope_i),
    .hit_noise_i        (hit_noise_i),
    .result_valid_o     (result_valid_o),
    .hit_accepted_o     (hit_accepted_o),
    .coincidence_o      (coincidence_o),
    .real_hit_count_o   (real_hit_count_o),
    .real_x_count_o     (real_x_count_o),
    .real_uv_count_o    (real_uv_count_o),
    .low_resolution_o   (low_resolution_o),
    .plane_mask_o       (plane_mask_o)
  );

  // every accepted item yields its result after the fixed latency
  `TRHC_ASSERT_LAT(a_item_result, start && !busy, result_valid_o, "item result missing")
  // a result only shows once the sequencer is back to idle
  `TRHC_ASSERT_IMP(a_result_idle, result_valid_o, !busy, "result while busy")
  // one strobe per item
  `TRHC_ASSERT_NXT(a_single_strobe, result_valid_o, !result_valid_o, "double result strobe")

endmodule
